>>> src/ttks_pkg.sv
// Shared types, codes and small helper functions of the text-to-keystroke sequencer.
// Depends on nothing; every other file but ttks_ram imports it.
`timescale 1ns / 1ps

package ttks_pkg;

  // Input command codes.
  localparam logic IN_LOAD = 1'b0;
  localparam logic IN_BYTE = 1'b1;

  // Character codes that map to the delete key.
  localparam logic [15:0] CODE_BACKSPACE = 16'h0008;
  localparam logic [15:0] CODE_DELETE    = 16'h007F;

  // Lead byte patterns of two- and three-byte sequences.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;

  // Digit range for the digit-key skip option.
  localparam logic [15:0] CHAR_ZERO = 16'h0030;
  localparam logic [15:0] CHAR_NINE = 16'h0039;

  // Modifier bits.
  localparam int MOD_SHIFT_BIT = 0;
  localparam int MOD_ALT_BIT   = 1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ENTRIES = 3'd0;
  localparam logic [2:0] REG_SHIFT   = 3'd1;
  localparam logic [2:0] REG_ALT     = 3'd2;
  localparam logic [2:0] REG_DELETE  = 3'd3;
  localparam logic [2:0] REG_SKIP    = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOOKUP,
    OP_DELETE
  } op_t;

  // One request from the front to the back. For lookups the code sits in chars[15:0].
  typedef struct packed {
    op_t         op;
    logic [5:0]  index;
    logic [63:0] chars;
    logic [9:0]  scan;
  } cmd_t;

  typedef struct packed {
    logic [6:0] entries_in_use;
    logic [9:0] shift_scan;
    logic [9:0] alt_scan;
    logic [9:0] delete_scan;
    logic       skip_digits;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    STEP_SHIFT_PRESS,
    STEP_ALT_PRESS,
    STEP_KEY_PRESS,
    STEP_KEY_RELEASE,
    STEP_ALT_RELEASE,
    STEP_SHIFT_RELEASE
  } step_t;

  function automatic step_t first_step(input logic [1:0] mods);
    if (mods[MOD_SHIFT_BIT]) return STEP_SHIFT_PRESS;
    if (mods[MOD_ALT_BIT])   return STEP_ALT_PRESS;
    return STEP_KEY_PRESS;
  endfunction

  function automatic step_t final_step(input logic [1:0] mods);
    if (mods[MOD_SHIFT_BIT]) return STEP_SHIFT_RELEASE;
    if (mods[MOD_ALT_BIT])   return STEP_ALT_RELEASE;
    return STEP_KEY_RELEASE;
  endfunction

  function automatic step_t next_step(input step_t s, input logic [1:0] mods);
    step_t r;
    case (s)
      STEP_SHIFT_PRESS:   r = mods[MOD_ALT_BIT] ? STEP_ALT_PRESS : STEP_KEY_PRESS;
      STEP_ALT_PRESS:     r = STEP_KEY_PRESS;
      STEP_KEY_PRESS:     r = STEP_KEY_RELEASE;
      STEP_KEY_RELEASE:   r = mods[MOD_ALT_BIT] ? STEP_ALT_RELEASE : STEP_SHIFT_RELEASE;
      STEP_ALT_RELEASE:   r = STEP_SHIFT_RELEASE;
      default:            r = STEP_SHIFT_RELEASE;
    endcase
    return r;
  endfunction

endpackage

>>> src/text_to_keystroke_sequencer.sv
// Top level of the text-to-keystroke sequencer: configuration registers, front end,
// request queue and back end. Depends on ttks_pkg, ttks_front, ttks_fifo and ttks_back.
`timescale 1ns / 1ps

// The sequencer turns typed text into key press and release events for a keyboard
// whose layout sits in a keymap table of TABLE_DEPTH slots. A load request (cmd = 0)
// writes one slot; a typed byte (cmd = 1) is merged with earlier bytes into a 16-bit
// character code, and each complete code yields two to six events on the result
// queue: delete key for backspace and delete codes, otherwise the first matching
// table key wrapped in shift and alt presses, or a flagged scan code 0 when nothing
// matches. Input requests go through a short queue, so bytes and loads keep being
// taken while a lookup runs or while results wait to be popped, until the queue
// fills. A byte that finishes no code stays in the front end, and a load is a
// single table write in the back end. A lookup scans min(entries_in_use, TABLE_DEPTH)
// slots one by one through the single read port of the keymap RAM, then emits one
// event per cycle while the result side keeps popping; the back end takes no new
// request until the last event of a code is out. Table slots that were never loaded
// must not lie within the searched range. The configuration registers must only be
// written while the block is idle.

module text_to_keystroke_sequencer
  import ttks_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [5:0]  entry_index,
  input  logic [15:0] plain_char,
  input  logic [15:0] shifted_char,
  input  logic [15:0] alt_char,
  input  logic [15:0] shift_alt_char,
  input  logic [9:0]  entry_scan_code,
  input  logic [7:0]  typed_byte,
  // result requests
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  scan_code,
  output logic        pressed,
  output logic        unknown_char,
  output logic        last_event,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_sel;

  logic       q_push;
  cmd_t       q_wr;
  logic       q_full;
  logic       q_pop;
  cmd_t       q_rd;
  logic       q_valid;
  logic       out_valid;

  // Registers sit at byte addresses 4*i; the low two address bits are ignored.
  assign reg_sel   = paddr[4:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_in_use <= 7'd0;
      cfg.shift_scan     <= 10'd0;
      cfg.alt_scan       <= 10'd0;
      cfg.delete_scan    <= 10'd0;
      cfg.skip_digits    <= 1'b1;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ENTRIES: cfg.entries_in_use <= pwdata[6:0];
        REG_SHIFT:   cfg.shift_scan     <= pwdata[9:0];
        REG_ALT:     cfg.alt_scan       <= pwdata[9:0];
        REG_DELETE:  cfg.delete_scan    <= pwdata[9:0];
        REG_SKIP:    cfg.skip_digits    <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENTRIES: prdata = {25'd0, cfg.entries_in_use};
      REG_SHIFT:   prdata = {22'd0, cfg.shift_scan};
      REG_ALT:     prdata = {22'd0, cfg.alt_scan};
      REG_DELETE:  prdata = {22'd0, cfg.delete_scan};
      REG_SKIP:    prdata = {31'd0, cfg.skip_digits};
      default:     prdata = 32'd0;
    endcase
  end

  // The front end classifies each request and holds the partial multi-byte code.
  ttks_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .plain_char     (plain_char),
    .shifted_char   (shifted_char),
    .alt_char       (alt_char),
    .shift_alt_char (shift_alt_char),
    .entry_scan_code(entry_scan_code),
    .typed_byte     (typed_byte),
    .q_push         (q_push),
    .q_cmd          (q_wr),
    .q_full         (q_full)
  );

  // Loads travel through the same queue as codes, so table writes stay in order
  // with the lookups that came before them.
  ttks_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rd),
    .not_empty(q_valid)
  );

  // The back end scans the keymap and fills the one-entry output register.
  ttks_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (q_rd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_scan   (scan_code),
    .out_pressed(pressed),
    .out_unknown(unknown_char),
    .out_last   (last_event),
    .out_take   (pop)
  );

  assign empty = !out_valid;

  // An unmatched code is always reported on scan code 0.
  a_unknown_scan: assert property (@(posedge clk) disable iff (rst)
    (!empty && unknown_char) |-> (scan_code == 10'd0))
    else $error("unknown character event carries a nonzero scan code");

  // Every sequence ends on a release.
  a_last_release: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_event) |-> !pressed)
    else $error("final event of a sequence is a press");

  // A write to the entry count register lands on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (reg_sel == REG_ENTRIES)) |=> (cfg.entries_in_use == $past(pwdata[6:0])))
    else $error("entry count register did not take the written value");

endmodule

>>> src/ttks_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ttks_ram #(
  parameter int WIDTH = 74,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ttks_fifo.sv
// Short request queue between the front and the back of the sequencer.
// Depends on ttks_pkg for the request type.
`timescale 1ns / 1ps

module ttks_fifo
  import ttks_pkg::*;
#(
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic not_empty
);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

>>> src/ttks_front.sv
// Front end: accepts input items, merges typed bytes into character codes and queues
// table loads and complete codes. Depends on ttks_pkg.
`timescale 1ns / 1ps

module ttks_front
  import ttks_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [5:0]  entry_index,
  input  logic [15:0] plain_char,
  input  logic [15:0] shifted_char,
  input  logic [15:0] alt_char,
  input  logic [15:0] shift_alt_char,
  input  logic [9:0]  entry_scan_code,
  input  logic [7:0]  typed_byte,
  output logic        q_push,
  output cmd_t        q_cmd,
  input  logic        q_full
);

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic [15:0] partial;
  logic [15:0] partial_next;
  logic        accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= 16'd0;
    end else begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

  always_comb begin
    logic [15:0] code;
    logic        emit;
    code         = {8'd0, typed_byte};
    emit         = 1'b0;
    pending_next = pending;
    partial_next = partial;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.op     = OP_LOAD;
    q_cmd.index  = entry_index;
    q_cmd.chars  = {shift_alt_char, alt_char, shifted_char, plain_char};
    q_cmd.scan   = entry_scan_code;
    if (accept) begin
      if (cmd == IN_LOAD) begin
        q_push = 1'b1;
      end else if (pending == 2'd2) begin
        partial_next = partial + {4'd0, typed_byte[5:0], 6'd0};
        pending_next = 2'd1;
      end else if (pending == 2'd1) begin
        code         = partial + {10'd0, typed_byte[5:0]};
        emit         = 1'b1;
        pending_next = 2'd0;
        partial_next = 16'd0;
      end else if ((typed_byte & LEAD2_MASK) == LEAD2_VAL) begin
        partial_next = {5'd0, typed_byte[4:0], 6'd0};
        pending_next = 2'd1;
      end else if ((typed_byte & LEAD3_MASK) == LEAD3_VAL) begin
        partial_next = {typed_byte[3:0], 12'd0};
        pending_next = 2'd2;
      end else begin
        emit = 1'b1;
      end
    end
    if (emit) begin
      q_push      = 1'b1;
      q_cmd.op    = (code inside {CODE_BACKSPACE, CODE_DELETE}) ? OP_DELETE : OP_LOOKUP;
      q_cmd.chars = {48'd0, code};
    end
  end

endmodule

>>> src/ttks_back.sv
// Back end: owns the keymap RAM, carries out loads, scans the table for each code and
// emits the key events into the output register. Depends on ttks_pkg and ttks_ram.
`timescale 1ns / 1ps

module ttks_back
  import ttks_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  output logic [9:0] out_scan,
  output logic       out_pressed,
  output logic       out_unknown,
  output logic       out_last,
  input  logic       out_take
);

  back_state_t   state;
  back_state_t   state_next;
  logic [15:0]   code;
  logic [15:0]   code_next;
  logic [9:0]    key_scan;
  logic [9:0]    key_scan_next;
  logic [1:0]    mods;
  logic [1:0]    mods_next;
  logic          unknown;
  logic          unknown_next;
  step_t         step;
  step_t         step_next;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_idx_next;
  logic          chk_valid;
  logic          chk_valid_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [73:0]   ram_rdata;
  logic [10:0]   load_idx;
  logic [10:0]   limit_wide;
  logic [CW-1:0] limit;
  logic          out_free;
  logic          emit;
  logic [9:0]    ev_scan;
  logic          ev_pressed;

  assign load_idx  = {5'd0, q_cmd.index};
  assign ram_waddr = load_idx[AW-1:0];
  assign limit_wide = ({4'd0, cfg.entries_in_use} > 11'(TABLE_DEPTH)) ?
                      11'(TABLE_DEPTH) : {4'd0, cfg.entries_in_use};
  assign limit     = limit_wide[CW-1:0];
  assign out_free  = !out_valid || out_take;

  ttks_ram #(
    .WIDTH(74),
    .DEPTH(TABLE_DEPTH)
  ) u_keymap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({q_cmd.scan, q_cmd.chars}),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
      rd_idx    <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= chk_valid_next;
      rd_idx    <= rd_idx_next;
      if (emit)          out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    code     <= code_next;
    key_scan <= key_scan_next;
    mods     <= mods_next;
    unknown  <= unknown_next;
    step     <= step_next;
    if (emit) begin
      out_scan    <= ev_scan;
      out_pressed <= ev_pressed;
      out_unknown <= unknown;
      out_last    <= (step == final_step(mods));
    end
  end

  // Event for the current step of the sequence.
  always_comb begin
    case (step)
      STEP_SHIFT_PRESS:   begin ev_scan = cfg.shift_scan; ev_pressed = 1'b1; end
      STEP_ALT_PRESS:     begin ev_scan = cfg.alt_scan;   ev_pressed = 1'b1; end
      STEP_KEY_PRESS:     begin ev_scan = key_scan;       ev_pressed = 1'b1; end
      STEP_KEY_RELEASE:   begin ev_scan = key_scan;       ev_pressed = 1'b0; end
      STEP_ALT_RELEASE:   begin ev_scan = cfg.alt_scan;   ev_pressed = 1'b0; end
      default:            begin ev_scan = cfg.shift_scan; ev_pressed = 1'b0; end
    endcase
  end

  always_comb begin
    logic [15:0] e_plain;
    logic [15:0] e_shift;
    logic [15:0] e_alt;
    logic [15:0] e_shalt;
    logic [9:0]  e_scan;
    logic        skip;
    logic        hit;
    logic [1:0]  hit_mods;
    e_plain  = ram_rdata[15:0];
    e_shift  = ram_rdata[31:16];
    e_alt    = ram_rdata[47:32];
    e_shalt  = ram_rdata[63:48];
    e_scan   = ram_rdata[73:64];
    skip     = (cfg.skip_digits && (e_plain inside {[CHAR_ZERO:CHAR_NINE]})) ||
               (e_scan == 10'd0);
    hit      = !skip && ((code == e_plain) || (code == e_shift) ||
                         (code == e_alt) || (code == e_shalt));
    if (code == e_plain)      hit_mods = 2'b00;
    else if (code == e_shift) hit_mods = 2'b01;
    else if (code == e_alt)   hit_mods = 2'b10;
    else                      hit_mods = 2'b11;

    state_next     = state;
    code_next      = code;
    key_scan_next  = key_scan;
    mods_next      = mods;
    unknown_next   = unknown;
    step_next      = step;
    rd_idx_next    = rd_idx;
    chk_valid_next = chk_valid;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    emit           = 1'b0;

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_LOAD: begin
              ram_we = (load_idx < 11'(TABLE_DEPTH));
            end
            OP_DELETE: begin
              key_scan_next = cfg.delete_scan;
              mods_next     = 2'b00;
              unknown_next  = 1'b0;
              step_next     = STEP_KEY_PRESS;
              state_next    = BK_EMIT;
            end
            default: begin
              code_next      = q_cmd.chars[15:0];
              rd_idx_next    = '0;
              chk_valid_next = 1'b0;
              mods_next      = 2'b00;
              if (limit == '0) begin
                key_scan_next = 10'd0;
                unknown_next  = 1'b1;
                step_next     = STEP_KEY_PRESS;
                state_next    = BK_EMIT;
              end else begin
                state_next = BK_SCAN;
              end
            end
          endcase
        end
      end

      BK_SCAN: begin
        // The RAM returns the entry at rd_idx - 1 while rd_idx is being read.
        if (chk_valid && hit) begin
          key_scan_next  = e_scan;
          mods_next      = hit_mods;
          unknown_next   = 1'b0;
          step_next      = first_step(hit_mods);
          chk_valid_next = 1'b0;
          state_next     = BK_EMIT;
        end else if (chk_valid && (rd_idx == limit)) begin
          key_scan_next  = 10'd0;
          mods_next      = 2'b00;
          unknown_next   = 1'b1;
          step_next      = STEP_KEY_PRESS;
          chk_valid_next = 1'b0;
          state_next     = BK_EMIT;
        end else begin
          rd_idx_next    = rd_idx + 1'b1;
          chk_valid_next = 1'b1;
        end
      end

      BK_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (step == final_step(mods)) begin
            state_next = BK_IDLE;
          end else begin
            step_next = next_step(step, mods);
          end
        end
      end

      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for text_to_keystroke_sequencer: directed and random keymap loads
// and typed text, checked event by event against a predictor of the keystroke sequence.
// Depends on ttks_pkg and the RTL of the sequencer; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
  import ttks_pkg::*;

  localparam int KEYMAP_SLOTS   = 64;
  localparam int HOLD_CYCLES    = 350;   // long receiver stall that backs the block up
  localparam int SETTLE_CYCLES  = 200;   // covers a full 64-slot search plus the queue
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving on either side
  localparam int ITEMS_PER_PHASE = 10;
  localparam logic [7:0] CONT_MARK = 8'h80;  // 10xxxxxx continuation byte
  localparam logic [7:0] CONT_BITS = 8'h3F;

  // One input request as the sender presents it.
  typedef struct packed {
    logic        cmd;
    logic [5:0]  slot;
    logic [15:0] plain;
    logic [15:0] shifted;
    logic [15:0] alt;
    logic [15:0] shift_alt;
    logic [9:0]  scan;
    logic [7:0]  typed;
  } request_t;

  // One key event on the result side.
  typedef struct packed {
    logic [9:0] scan;
    logic       pressed;
    logic       unknown;
    logic       closing;
  } keystroke_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = 1'b0;
  logic [5:0]  entry_index = '0;
  logic [15:0] plain_char = '0;
  logic [15:0] shifted_char = '0;
  logic [15:0] alt_char = '0;
  logic [15:0] shift_alt_char = '0;
  logic [9:0]  entry_scan_code = '0;
  logic [7:0]  typed_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [9:0]  scan_code;
  logic        pressed;
  logic        unknown_char;
  logic        last_event;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_to_keystroke_sequencer i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .plain_char     (plain_char),
    .shifted_char   (shifted_char),
    .alt_char       (alt_char),
    .shift_alt_char (shift_alt_char),
    .entry_scan_code(entry_scan_code),
    .typed_byte     (typed_byte),
    .empty          (empty),
    .pop            (pop),
    .scan_code      (scan_code),
    .pressed        (pressed),
    .unknown_char   (unknown_char),
    .last_event     (last_event),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  // Requests waiting to be offered, oldest first, and the key events still owed by the block.
  request_t   key_requests[$];
  keystroke_t expected_keystrokes[$];
  // Every character code ever loaded into the keymap; much of the typed text is drawn from it.
  logic [15:0] keymap_codes[$];

  // Predictor state: the keymap, the partial UTF-8 merge and the register copies.
  logic [63:0] keymap_chars [KEYMAP_SLOTS];
  logic [9:0]  keymap_scan  [KEYMAP_SLOTS];
  logic [1:0]  bytes_owed = '0;
  logic [15:0] code_so_far = '0;
  logic [6:0]  cfg_entries = '0;
  logic [9:0]  cfg_shift = '0;
  logic [9:0]  cfg_alt = '0;
  logic [9:0]  cfg_delete = '0;
  logic        cfg_skip = 1'b1;

  int          mismatch_count = 0;
  int          stalled_cycles = 0;
  request_t    accepted_request;
  keystroke_t  seen_keystroke;
  keystroke_t  wanted_keystroke;

  // Receiver stall control. The main sequence raises hold_wanted once; the receiver then
  // counts out the long stall on its own.
  logic        hold_wanted = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  logic [7:0]  stall_pattern = 8'hFF;
  int          pattern_age = 0;

  // Sender burst control.
  int          send_burst = 1;
  int          send_gap = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function void owe_keystroke(input logic [9:0] scan, input logic down, input logic unknown,
                              input logic closing);
    keystroke_t k;
    k.scan    = scan;
    k.pressed = down;
    k.unknown = unknown;
    k.closing = closing;
    expected_keystrokes.push_back(k);
  endfunction

  // Works out the events of one complete character code: delete key, a matched table key
  // wrapped in its modifiers, or a flagged scan code 0 when nothing matches.
  function void emit_character(input logic [15:0] code);
    logic [1:0]  mods;
    logic [9:0]  key;
    logic        found;
    logic        unknown;
    logic [15:0] plain;
    int          limit;
    mods    = '0;
    key     = '0;
    found   = 1'b0;
    unknown = 1'b0;
    if (code == CODE_BACKSPACE || code == CODE_DELETE) begin
      key = cfg_delete;
    end else begin
      limit = (cfg_entries > KEYMAP_SLOTS) ? KEYMAP_SLOTS : int'(cfg_entries);
      for (int x = 0; x < limit && !found; x++) begin
        plain = keymap_chars[x][15:0];
        // Digit keys are passed over when the option is on, absent keys always.
        if (!(cfg_skip && plain >= CHAR_ZERO && plain <= CHAR_NINE) && keymap_scan[x] != '0) begin
          if (code == plain) begin
            found = 1'b1;
          end else if (code == keymap_chars[x][31:16]) begin
            found = 1'b1;
            mods[MOD_SHIFT_BIT] = 1'b1;
          end else if (code == keymap_chars[x][47:32]) begin
            found = 1'b1;
            mods[MOD_ALT_BIT] = 1'b1;
          end else if (code == keymap_chars[x][63:48]) begin
            found = 1'b1;
            mods = '1;
          end
          if (found) key = keymap_scan[x];
        end
      end
      unknown = !found;
    end
    if (mods[MOD_SHIFT_BIT]) owe_keystroke(cfg_shift, 1'b1, unknown, 1'b0);
    if (mods[MOD_ALT_BIT])   owe_keystroke(cfg_alt, 1'b1, unknown, 1'b0);
    owe_keystroke(key, 1'b1, unknown, 1'b0);
    owe_keystroke(key, 1'b0, unknown, mods == '0);
    if (mods[MOD_ALT_BIT])   owe_keystroke(cfg_alt, 1'b0, unknown, !mods[MOD_SHIFT_BIT]);
    if (mods[MOD_SHIFT_BIT]) owe_keystroke(cfg_shift, 1'b0, unknown, 1'b1);
  endfunction

  // Applies one accepted request to the predictor state. Loads leave a pending merge alone;
  // while continuation bytes are owed, any byte is taken as one.
  function void predict_request(input request_t r);
    if (r.cmd == IN_LOAD) begin
      keymap_chars[r.slot] = {r.shift_alt, r.alt, r.shifted, r.plain};
      keymap_scan[r.slot]  = r.scan;
    end else if (bytes_owed == 2'd2) begin
      code_so_far = code_so_far + {4'b0, r.typed[5:0], 6'b0};
      bytes_owed  = 2'd1;
    end else if (bytes_owed == 2'd1) begin
      emit_character(code_so_far + {10'b0, r.typed[5:0]});
      bytes_owed  = 2'd0;
      code_so_far = '0;
    end else if ((r.typed & LEAD2_MASK) == LEAD2_VAL) begin
      code_so_far = {5'b0, r.typed[4:0], 6'b0};
      bytes_owed  = 2'd1;
    end else if ((r.typed & LEAD3_MASK) == LEAD3_VAL) begin
      code_so_far = {r.typed[3:0], 12'b0};
      bytes_owed  = 2'd2;
    end else begin
      emit_character({8'b0, r.typed});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // The fields that a request does not use are still randomized so that every bit toggles.
  function void queue_load(input logic [5:0] slot, input logic [15:0] plain,
                           input logic [15:0] shifted, input logic [15:0] alt,
                           input logic [15:0] shift_alt, input logic [9:0] scan);
    request_t r;
    r.cmd       = IN_LOAD;
    r.slot      = slot;
    r.plain     = plain;
    r.shifted   = shifted;
    r.alt       = alt;
    r.shift_alt = shift_alt;
    r.scan      = scan;
    r.typed     = 8'($urandom_range(0, 255));
    key_requests.push_back(r);
    keymap_codes.push_back(plain);
    keymap_codes.push_back(shifted);
    keymap_codes.push_back(alt);
    keymap_codes.push_back(shift_alt);
  endfunction

  function void queue_byte(input logic [7:0] b);
    request_t r;
    r.cmd       = IN_BYTE;
    r.slot      = 6'($urandom_range(0, 63));
    r.plain     = 16'($urandom);
    r.shifted   = 16'($urandom);
    r.alt       = 16'($urandom);
    r.shift_alt = 16'($urandom);
    r.scan      = 10'($urandom_range(0, 1023));
    r.typed     = b;
    key_requests.push_back(r);
  endfunction

  // Types one character code as well-formed UTF-8.
  function void queue_code(input logic [15:0] code);
    if (code < 16'h0080) begin
      queue_byte(code[7:0]);
    end else if (code < 16'h0800) begin
      queue_byte(LEAD2_VAL | {3'b0, code[10:6]});
      queue_byte(CONT_MARK | {2'b0, code[5:0]});
    end else begin
      queue_byte(LEAD3_VAL | {4'b0, code[15:12]});
      queue_byte(CONT_MARK | {2'b0, code[11:6]});
      queue_byte(CONT_MARK | {2'b0, code[5:0]});
    end
  endfunction

  // Keymap characters lean toward printable text and digits, with wide and odd codes mixed in.
  function logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(16'h20, 16'h7E));
      4:          return CHAR_ZERO + 16'($urandom_range(0, 9));
      5:          return 16'($urandom_range(16'h80, 16'h7FF));
      6:          return 16'($urandom_range(16'h800, 16'hFFFF));
      7:          return 16'($urandom);
      8:          return 16'($urandom_range(0, 31));
      default:    return $urandom_range(0, 1) ? CODE_BACKSPACE : CODE_DELETE;
    endcase
  endfunction

  // About one key in eight is marked absent.
  function logic [9:0] pick_scan();
    return ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
  endfunction

  function void queue_random_load(input logic [5:0] slot);
    queue_load(slot, pick_char(), pick_char(), pick_char(), pick_char(), pick_scan());
  endfunction

  // Well-formed text, mostly of characters that sit in the keymap, plus raw noise, delete
  // bytes, broken multi-byte sequences and keymap reloads.
  task automatic queue_random_items(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        queue_random_load(6'($urandom_range(0, 63)));
      end else if (kind < 62) begin
        if (keymap_codes.size() > 0 && $urandom_range(0, 9) < 8)
          queue_code(keymap_codes[$urandom_range(0, keymap_codes.size() - 1)]);
        else
          queue_code(pick_char());
      end else if (kind < 80) begin
        queue_byte(8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
        queue_byte($urandom_range(0, 1) ? CODE_BACKSPACE[7:0] : CODE_DELETE[7:0]);
      end else begin
        // A lead byte followed by whatever comes: the block takes it as a continuation.
        queue_byte(8'($urandom_range(8'hC0, 8'hEF)));
        queue_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [2:0] reg_index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes every register and mirrors the values into the predictor. Only called while the
  // block is idle, so nothing in flight sees the change.
  task automatic apply_settings(input logic [6:0] entries, input logic [9:0] shift_scan,
                                input logic [9:0] alt_scan, input logic [9:0] delete_scan,
                                input logic skip_digits);
    write_reg(REG_ENTRIES, {25'b0, entries});
    write_reg(REG_SHIFT,   {22'b0, shift_scan});
    write_reg(REG_ALT,     {22'b0, alt_scan});
    write_reg(REG_DELETE,  {22'b0, delete_scan});
    write_reg(REG_SKIP,    {31'b0, skip_digits});
    cfg_entries = entries;
    cfg_shift   = shift_scan;
    cfg_alt     = alt_scan;
    cfg_delete  = delete_scan;
    cfg_skip    = skip_digits;
  endtask

  // Waits until every request is taken and every event has come out, then lets the block
  // finish any load or partial byte that produces no event.
  task automatic drain_and_settle();
    while (key_requests.size() != 0 || expected_keystrokes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers the oldest queued request in bursts separated by random gaps.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      push     <= 1'b0;
    end else if (key_requests.size() > 0) begin
      push            <= 1'b1;
      cmd             <= key_requests[0].cmd;
      entry_index     <= key_requests[0].slot;
      plain_char      <= key_requests[0].plain;
      shifted_char    <= key_requests[0].shifted;
      alt_char        <= key_requests[0].alt;
      shift_alt_char  <= key_requests[0].shift_alt;
      entry_scan_code <= key_requests[0].scan;
      typed_byte      <= key_requests[0].typed;
      if (send_burst > 1) begin
        send_burst <= send_burst - 1;
      end else begin
        // Mostly short bursts, now and then a long one; a quarter of the bursts have no gap.
        send_burst <= $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
        send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      push <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pops on a rotating pattern that is replaced whenever its age counter wraps,
  // and once holds off for a long stretch so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      pop       <= 1'b0;
    end else begin
      pop <= stall_pattern[0];
      if (pattern_age == 63) begin
        pattern_age   <= 0;
        stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        pattern_age   <= pattern_age + 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each popped event against the oldest expectation, feeds each accepted
  // request to the predictor, and ends a run in which nothing moves for too long.
  // The result check comes first, since a request cannot cause an event at its own edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        seen_keystroke = '{scan: scan_code, pressed: pressed, unknown: unknown_char,
                           closing: last_event};
        if (expected_keystrokes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected event scan=%0d pressed=%0b unknown=%0b last=%0b",
                     $time, scan_code, pressed, unknown_char, last_event);
        end else begin
          wanted_keystroke = expected_keystrokes.pop_front();
          if (seen_keystroke != wanted_keystroke) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: event mismatch: expected scan=%0d pressed=%0b unknown=%0b ",
                        "last=%0b, got scan=%0d pressed=%0b unknown=%0b last=%0b"},
                       $time, wanted_keystroke.scan, wanted_keystroke.pressed,
                       wanted_keystroke.unknown, wanted_keystroke.closing,
                       scan_code, pressed, unknown_char, last_event);
          end
        end
      end
      if (push && !full) begin
        accepted_request = key_requests.pop_front();
        predict_request(accepted_request);
      end
      if ((push && !full) || (pop && !empty)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed phase, then random phases under different settings.
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed phase: five searched slots, extreme shift code, digit keys skipped.
    apply_settings(7'd5, 10'h3FF, 10'h001, 10'h200, 1'b1);
    // Slot 0: a, A, a-umlaut (two bytes), euro sign (three bytes).
    queue_load(6'd0, 16'h0061, 16'h0041, 16'h00E4, 16'h20AC, 10'd30);
    // Slot 1 has a digit as its plain character, so with the skip on its 'q' is never found.
    queue_load(6'd1, 16'h0035, 16'h0025, 16'h0071, 16'h0051, 10'd6);
    // Slot 2 is absent; its 'b' must fall through to slot 4.
    queue_load(6'd2, 16'h0062, 16'h0042, 16'h0000, 16'h0000, 10'd0);
    // Slot 3 repeats 'a' as its alt character; slot 0 must win.
    queue_load(6'd3, 16'hFFFF, 16'h0000, 16'h0061, 16'h07FF, 10'd1);
    queue_load(6'd4, 16'h0062, 16'h0800, 16'h0080, 16'h0063, 10'd1023);
    queue_byte(CODE_BACKSPACE[7:0]);
    queue_byte(CODE_DELETE[7:0]);
    queue_byte(8'h61);                 // plain match
    queue_byte(8'h41);                 // shift
    queue_code(16'h00E4);              // alt, two-byte text
    // Euro sign with a load between its bytes: the merge must survive it.
    queue_byte(8'hE2);
    queue_load(6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h2AA);
    queue_byte(8'h82);
    queue_byte(8'hAC);                 // shift and alt
    queue_byte(8'h71);                 // only on a digit key, so unknown
    queue_byte(8'h62);
    queue_byte(8'h00);                 // shifted code zero on slot 3
    queue_code(16'hFFFF);              // plain code of all ones
    queue_byte(8'hC0);                 // merged code 0x08 is a delete
    queue_byte(8'h88);
    queue_byte(8'hC1);                 // a backspace byte taken as continuation
    queue_byte(CODE_BACKSPACE[7:0]);
    queue_byte(8'h80);                 // stray continuation used raw
    queue_byte(8'hFF);                 // raw and unmatched
    drain_and_settle();

    // No slot searched, all scan codes zero; meanwhile fill the whole keymap.
    apply_settings(7'd0, 10'd0, 10'd0, 10'd0, 1'b0);
    for (int s = 0; s < KEYMAP_SLOTS; s++) queue_random_load(6'(s));
    queue_random_items(ITEMS_PER_PHASE);
    drain_and_settle();

    // Count above the table size searches every slot; scan codes at their maximum.
    apply_settings(7'd127, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1);
    queue_random_items(ITEMS_PER_PHASE);
    drain_and_settle();

    // Full table with digit keys searched, and the long receiver stall.
    apply_settings(7'd64, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   10'($urandom_range(0, 1023)), 1'b0);
    hold_wanted = 1'b1;
    queue_random_items(ITEMS_PER_PHASE);
    drain_and_settle();

    for (int p = 0; p < 2; p++) begin
      apply_settings(7'($urandom_range(1, 64)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)));
      queue_random_items(ITEMS_PER_PHASE);
      drain_and_settle();
    end

    if (mismatch_count == 0 && expected_keystrokes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
